// ===== src/stcm_pkg.sv =====
// Shared types, constants and the color stop table for the scalar-to-color mapper.
// Used by scalar_to_color_map_core and stcm_lerp; depends on nothing else.
package stcm_pkg;

  // Field and arithmetic widths
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int OFFSET_W  = 24;
  localparam int CHAN_W    = 8;
  localparam int FRAC_W    = 16;
  localparam int V_W       = FRAC_W + 1;          // unsigned Q1.16, 65536 = 1.0
  localparam int PROD_W    = SAMPLE_W + GAIN_W;   // Q16.16
  localparam int SUM_W     = PROD_W + 1;          // product plus offset
  localparam int TBL_IDX_W = 4;
  localparam int TABLE_LEN = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = OFFSET_W;

  localparam logic [V_W-1:0] ONE_Q16 = V_W'(1) << FRAC_W;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN   = 2'd0,
    CFG_OFFSET = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb_t;

  // Blue-cyan-yellow-red stops; indexes past the table saturate to dark red
  function automatic rgb_t color_lookup(input logic [TBL_IDX_W-1:0] idx);
    rgb_t c;
    case (idx) inside
      4'd0:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd166};
      4'd1:    c = '{r: 8'd0,   g: 8'd89,  b: 8'd255};
      4'd2:    c = '{r: 8'd38,  g: 8'd255, b: 8'd242};
      4'd3:    c = '{r: 8'd242, g: 8'd255, b: 8'd38};
      4'd4:    c = '{r: 8'd255, g: 8'd89,  b: 8'd0};
      default: c = '{r: 8'd166, g: 8'd0,   b: 8'd0};
    endcase
    return c;
  endfunction

endpackage

// ===== src/scalar_to_color_map_core.sv =====
// Scalar-to-color mapper: signed Q8.8 sample times gain plus offset, clamp, jet colormap.
// Depends on stcm_pkg and stcm_lerp.
//
// Each sample is scaled by the signed Q8.8 gain, shifted by the signed Q7.16 offset,
// clamped to [0,1] and mapped onto COLOR_STOPS-1 equal segments of a fixed
// blue-cyan-yellow-red table, giving one 8-bit RGB triple per sample. The block takes
// one sample per clock while in_stall is low; each result passes through four register
// stages, one each for the gain multiply, the offset add and clamp, the segment split
// with table lookup, and the per-channel blend. Every stage holds its own valid bit, so
// a stall on the result side is absorbed by empty stages before in_stall rises.
// Configuration writes are taken at any time (cfg_ready is always high) but must only
// be issued while no sample is in flight.
module scalar_to_color_map_core #(
  parameter int COLOR_STOPS = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Sample channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [stcm_pkg::SAMPLE_W-1:0] in_sample,
  // Color channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [stcm_pkg::CHAN_W-1:0]         out_red_out,
  output logic [stcm_pkg::CHAN_W-1:0]         out_green_out,
  output logic [stcm_pkg::CHAN_W-1:0]         out_blue_out,
  // Configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stcm_pkg::CFG_DAT_W-1:0]      cfg_data
);

  localparam int SEGS  = COLOR_STOPS - 1;
  localparam int SEG_W = $clog2(COLOR_STOPS);
  localparam int T_W   = stcm_pkg::FRAC_W + SEG_W;

  localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(SEGS - 1);

  // Configuration registers
  logic signed [stcm_pkg::GAIN_W-1:0]   gain_r;
  logic signed [stcm_pkg::OFFSET_W-1:0] offset_r;

  // Pipeline valid bits and per-stage ready
  logic vld1_r, vld2_r, vld3_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4;

  // Stage payloads
  logic signed [stcm_pkg::PROD_W-1:0] prod1_r;
  logic signed [stcm_pkg::SUM_W-1:0]  sum2;
  logic [stcm_pkg::V_W-1:0]           v2_nxt, v2_r;
  logic [T_W-1:0]                     t3;
  logic [SEG_W-1:0]                   seg_raw3, seg3, seg_hi3;
  logic [stcm_pkg::V_W-1:0]           f3_nxt, f3_r;
  stcm_pkg::rgb_t                     lo3_r, hi3_r;

  // Write configuration registers; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= stcm_pkg::GAIN_W'(256);
      offset_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (stcm_pkg::cfg_idx_t'(cfg_index))
        stcm_pkg::CFG_GAIN:   gain_r   <= cfg_data[stcm_pkg::GAIN_W-1:0];
        stcm_pkg::CFG_OFFSET: offset_r <= cfg_data[stcm_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage advances when it is empty or the stage after it advances
  assign rdy4     = !out_valid_r || !out_stall;
  assign rdy3     = !vld3_r || rdy4;
  assign rdy2     = !vld2_r || rdy3;
  assign rdy1     = !vld1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      vld3_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) vld1_r      <= in_valid;
      if (rdy2) vld2_r      <= vld1_r;
      if (rdy3) vld3_r      <= vld2_r;
      if (rdy4) out_valid_r <= vld3_r;
    end
  end

  // Stage 1: scale the sample by the gain (Q16.16)
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      prod1_r <= in_sample * gain_r;
    end
  end

  // Stage 2: add the offset and clamp to [0, 1.0]
  always_comb begin
    sum2 = stcm_pkg::SUM_W'(prod1_r) + stcm_pkg::SUM_W'(offset_r);
    if (sum2[stcm_pkg::SUM_W-1]) begin
      v2_nxt = '0;
    end else if (sum2 > $signed(stcm_pkg::SUM_W'(stcm_pkg::ONE_Q16))) begin
      v2_nxt = stcm_pkg::ONE_Q16;
    end else begin
      v2_nxt = sum2[stcm_pkg::V_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && vld1_r) begin
      v2_r <= v2_nxt;
    end
  end

  // Stage 3: split into segment and fraction, fetch both bounding stops
  always_comb begin
    t3       = T_W'(v2_r) * T_W'(SEGS);
    seg_raw3 = t3[T_W-1:stcm_pkg::FRAC_W];
    seg3     = (seg_raw3 > SEG_LAST) ? SEG_LAST : seg_raw3;
    seg_hi3  = seg3 + SEG_W'(1);
    f3_nxt   = stcm_pkg::V_W'(t3 - (T_W'(seg3) << stcm_pkg::FRAC_W));
  end

  always_ff @(posedge clk) begin
    if (rdy3 && vld2_r) begin
      f3_r  <= f3_nxt;
      lo3_r <= stcm_pkg::color_lookup(stcm_pkg::TBL_IDX_W'(seg3));
      hi3_r <= stcm_pkg::color_lookup(stcm_pkg::TBL_IDX_W'(seg_hi3));
    end
  end

  // Stage 4: blend each channel into the output register
  stcm_lerp u_lerp_r (
    .clk  (clk),
    .en   (rdy4 && vld3_r),
    .c_lo (lo3_r.r),
    .c_hi (hi3_r.r),
    .frac (f3_r),
    .y    (out_red_out)
  );

  stcm_lerp u_lerp_g (
    .clk  (clk),
    .en   (rdy4 && vld3_r),
    .c_lo (lo3_r.g),
    .c_hi (hi3_r.g),
    .frac (f3_r),
    .y    (out_green_out)
  );

  stcm_lerp u_lerp_b (
    .clk  (clk),
    .en   (rdy4 && vld3_r),
    .c_lo (lo3_r.b),
    .c_hi (hi3_r.b),
    .frac (f3_r),
    .y    (out_blue_out)
  );

  assign out_valid = out_valid_r;

  // Clamped value never exceeds 1.0
  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld2_r |-> (v2_r <= stcm_pkg::ONE_Q16))
    else $error("clamped value above 1.0");

  // Segment fraction stays within one segment
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld3_r |-> (f3_r <= stcm_pkg::ONE_Q16))
    else $error("segment fraction above 1.0");

  // Input stalls only when every stage is full and the output is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (vld1_r && vld2_r && vld3_r && out_valid_r && out_stall))
    else $error("input stalled with an empty stage");

endmodule

// ===== src/stcm_lerp.sv =====
// One color channel of the final blend stage: lo + (hi - lo) * f, rounded half up.
// Depends on stcm_pkg for widths.
module stcm_lerp (
  input  logic                         clk,
  input  logic                         en,
  input  logic [stcm_pkg::CHAN_W-1:0]  c_lo,
  input  logic [stcm_pkg::CHAN_W-1:0]  c_hi,
  input  logic [stcm_pkg::V_W-1:0]     frac,
  output logic [stcm_pkg::CHAN_W-1:0]  y
);

  localparam int D_W   = stcm_pkg::CHAN_W + 1;
  localparam int ACC_W = D_W + stcm_pkg::V_W + 1;

  logic signed [D_W-1:0]   diff;
  logic signed [ACC_W-1:0] acc;
  logic [stcm_pkg::CHAN_W-1:0] y_r;

  // Blend as lo*1.0 + diff*f plus half an LSB; result never goes negative
  always_comb begin
    diff = $signed({1'b0, c_hi}) - $signed({1'b0, c_lo});
    acc  = $signed(ACC_W'({c_lo, {stcm_pkg::FRAC_W{1'b0}}}))
         + ACC_W'(diff) * ACC_W'($signed({1'b0, frac}))
         + $signed(ACC_W'(1) << (stcm_pkg::FRAC_W - 1));
  end

  // Hold the channel value while the output is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= acc[stcm_pkg::FRAC_W +: stcm_pkg::CHAN_W];
    end
  end

  assign y = y_r;

endmodule

// ===== verif/scalar_to_color_map_core_tb.sv =====
// Self-checking testbench for scalar_to_color_map_core: directed rows, then random phases.
// Depends on stcm_pkg for the color and register index types; predicts each color locally.
`timescale 1ns / 100ps

module scalar_to_color_map_core_tb;

  localparam int     STOP_COUNT = 6;
  localparam int     STOP_ROWS  = 6;
  localparam longint SEGMENTS   = STOP_COUNT - 1;
  localparam longint UNIT_Q16   = 65536;
  localparam int     PIPE_DEPTH = 4;
  localparam int     PHASES     = 11;
  localparam int     PHASE_LEN  = 95;

  // Indexes past the two registers; the block drops writes to them
  localparam logic [stcm_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [stcm_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  // Color stops as 24'hRRGGBB, stop 0 in the low slot
  localparam logic [STOP_ROWS-1:0][23:0] STOP_TABLE = {
    24'hA60000, 24'hFF5900, 24'hF2FF26, 24'h26FFF2, 24'h0059FF, 24'h0000A6
  };
  localparam stcm_pkg::rgb_t DEEP_BLUE = stcm_pkg::rgb_t'(24'h0000A6);
  localparam stcm_pkg::rgb_t DARK_RED  = stcm_pkg::rgb_t'(24'hA60000);

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                           kind;
    logic [stcm_pkg::CFG_IDX_W-1:0]      reg_idx;
    logic [stcm_pkg::CFG_DAT_W-1:0]      word;
    logic                                typed;
    stcm_pkg::rgb_t                      color;
  } plan_row_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic signed [stcm_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [stcm_pkg::CHAN_W-1:0]          out_red_out;
  logic [stcm_pkg::CHAN_W-1:0]          out_green_out;
  logic [stcm_pkg::CHAN_W-1:0]          out_blue_out;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [stcm_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [stcm_pkg::CFG_DAT_W-1:0]       cfg_data = '0;

  // Local copy of the two registers
  logic signed [stcm_pkg::GAIN_W-1:0]   gain_q88 = 16'sd256;
  logic signed [stcm_pkg::OFFSET_W-1:0] offset_q716 = '0;

  stcm_pkg::rgb_t expected_colors [$];
  int   mismatches = 0;
  int   colors_taken = 0;
  int   taken_seen = 0;
  int   hold_cycles = 0;
  bit   tx_burst = 1'b0;
  bit   rx_burst = 1'b0;

  scalar_to_color_map_core #(
    .COLOR_STOPS(STOP_COUNT)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Scale, offset, clamp to [0,1], then blend the two stops around the point
  function automatic stcm_pkg::rgb_t jet_color(logic signed [stcm_pkg::SAMPLE_W-1:0] smp,
                                               logic signed [stcm_pkg::GAIN_W-1:0] g,
                                               logic signed [stcm_pkg::OFFSET_W-1:0] o);
    longint      w, v, t, seg, frac, acc;
    int          lo, hi;
    logic [23:0] c_lo, c_hi, mix;
    w = longint'(smp) * longint'(g) + longint'(o);
    v = (w < 0) ? 0 : (w > UNIT_Q16) ? UNIT_Q16 : w;
    t = v * SEGMENTS;
    seg = t >>> 16;
    if (seg > SEGMENTS - 1) seg = SEGMENTS - 1;
    frac = t - (seg <<< 16);
    // stops past the stored table saturate to the last one
    lo = (seg >= STOP_ROWS) ? STOP_ROWS - 1 : int'(seg);
    hi = (seg + 1 >= STOP_ROWS) ? STOP_ROWS - 1 : int'(seg) + 1;
    c_lo = STOP_TABLE[lo];
    c_hi = STOP_TABLE[hi];
    for (int ch = 0; ch < 3; ch++) begin
      acc = longint'(c_lo[8*ch +: 8]) * (UNIT_Q16 - frac)
          + longint'(c_hi[8*ch +: 8]) * frac + 32768;
      mix[8*ch +: 8] = acc[23:16];
    end
    return stcm_pkg::rgb_t'(mix);
  endfunction

  function automatic plan_row_t sample_row(logic [stcm_pkg::SAMPLE_W-1:0] s, logic typed,
                                           stcm_pkg::rgb_t c);
    plan_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.word = stcm_pkg::CFG_DAT_W'(s);
    r.typed = typed;
    r.color = c;
    return r;
  endfunction

  function automatic plan_row_t write_row(logic [stcm_pkg::CFG_IDX_W-1:0] idx,
                                          logic [stcm_pkg::CFG_DAT_W-1:0] d);
    plan_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.reg_idx = idx;
    r.word = d;
    return r;
  endfunction

  // Mostly aim the scaled value near [0,1]; otherwise extremes or anything
  function automatic logic [stcm_pkg::SAMPLE_W-1:0] pick_sample();
    longint target, s;
    if (gain_q88 != 0 && $urandom_range(0, 3) != 0) begin
      target = longint'($urandom_range(0, 71536)) - 3000;
      s = (target - longint'(offset_q716)) / longint'(gain_q88);
      if (s >= -32768 && s <= 32767) return s[stcm_pkg::SAMPLE_W-1:0];
    end
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Drive one sample after a random gap and hold it until the transfer
  task automatic send_sample(logic [stcm_pkg::SAMPLE_W-1:0] smp, logic typed,
                             stcm_pkg::rgb_t typed_rgb);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_sample <= 16'($urandom);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample <= smp;
    do @(posedge clk); while (in_stall);
    expected_colors.push_back(typed ? typed_rgb : jet_color(smp, gain_q88, offset_q716));
  endtask

  // Drop valid, wait for every color to come back, then let the pipe empty
  task automatic settle_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_colors.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  task automatic write_reg(logic [stcm_pkg::CFG_IDX_W-1:0] idx,
                           logic [stcm_pkg::CFG_DAT_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    if (idx == stcm_pkg::CFG_GAIN) gain_q88 = d[stcm_pkg::GAIN_W-1:0];
    else if (idx == stcm_pkg::CFG_OFFSET) offset_q716 = d;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pick a gain and offset for one phase, mostly with junk in the unused gain bits
  task automatic pick_phase_config();
    logic [stcm_pkg::CFG_DAT_W-1:0] g_word, o_word;
    case ($urandom_range(0, 4))
      0: g_word = 24'($urandom);
      1: g_word = {8'($urandom), 16'($urandom_range(1, 1024))};
      2: g_word = {8'($urandom), 16'(0 - int'($urandom_range(1, 1024)))};
      3: g_word = {8'($urandom), 16'd256};
      default: begin
        case ($urandom_range(0, 3))
          0:       g_word = 24'h008000;
          1:       g_word = 24'h007FFF;
          2:       g_word = 24'h000000;
          default: g_word = 24'h00FFFF;
        endcase
      end
    endcase
    case ($urandom_range(0, 3))
      0: o_word = 24'($urandom);
      1: o_word = 24'(int'($urandom_range(0, 200000)) - 70000);
      2: o_word = 24'h000000;
      default: o_word = $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
    endcase
    if ($urandom_range(0, 1)) begin
      write_reg(stcm_pkg::CFG_GAIN, g_word);
      write_reg(stcm_pkg::CFG_OFFSET, o_word);
    end else begin
      write_reg(stcm_pkg::CFG_OFFSET, o_word);
      write_reg(stcm_pkg::CFG_GAIN, g_word);
    end
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, 24'($urandom));
  endtask

  // Result side: after each transfer, stall for a random number of cycles
  always @(negedge clk) begin
    if (colors_taken != taken_seen) begin
      taken_seen = colors_taken;
      hold_cycles = rx_burst ? 0 : $urandom_range(0, 13);
    end
    out_stall <= (hold_cycles != 0);
    if (hold_cycles != 0) hold_cycles--;
  end

  // Compare each color transfer with the oldest expectation
  always @(posedge clk) begin : check_colors
    stcm_pkg::rgb_t want, got;
    if (out_valid && !out_stall) begin
      colors_taken++;
      got = '{r: out_red_out, g: out_green_out, b: out_blue_out};
      if (expected_colors.size() == 0) begin
        mismatches++;
        $display("%0t: expected no color, actual %0d %0d %0d",
                 $time, got.r, got.g, got.b);
      end else begin
        want = expected_colors.pop_front();
        for (int ch = 2; ch >= 0; ch--) begin
          if (got[8*ch +: 8] !== want[8*ch +: 8]) begin
            mismatches++;
            $display("%0t: %s expected %0d, actual %0d", $time,
                     (ch == 2) ? "red" : (ch == 1) ? "green" : "blue",
                     want[8*ch +: 8], got[8*ch +: 8]);
          end
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan [$];

    // After reset: unit gain, zero offset
    plan.push_back(sample_row(16'h0000, 1'b1, DEEP_BLUE));
    plan.push_back(sample_row(16'h0100, 1'b1, DARK_RED));   // exactly one
    plan.push_back(sample_row(16'h7FFF, 1'b1, DARK_RED));
    plan.push_back(sample_row(16'h8000, 1'b1, DEEP_BLUE));
    plan.push_back(sample_row(16'hFFFF, 1'b1, DEEP_BLUE));  // just below zero
    plan.push_back(sample_row(16'h0001, 1'b0, '0));
    plan.push_back(sample_row(16'h0033, 1'b0, '0));
    plan.push_back(sample_row(16'h0080, 1'b0, '0));
    plan.push_back(sample_row(16'h00FF, 1'b0, '0));
    // Writes past the last register change nothing
    plan.push_back(write_row(CFG_SPARE_2, 24'hFFFFFF));
    plan.push_back(write_row(CFG_SPARE_3, 24'h000000));
    plan.push_back(sample_row(16'h0100, 1'b1, DARK_RED));
    // Most negative gain flips the scale
    plan.push_back(write_row(stcm_pkg::CFG_GAIN, 24'h008000));
    plan.push_back(sample_row(16'h8000, 1'b1, DARK_RED));
    plan.push_back(sample_row(16'h7FFF, 1'b1, DEEP_BLUE));
    // Largest gain with the most negative offset
    plan.push_back(write_row(stcm_pkg::CFG_GAIN, 24'h007FFF));
    plan.push_back(write_row(stcm_pkg::CFG_OFFSET, 24'h800000));
    plan.push_back(sample_row(16'h7FFF, 1'b1, DARK_RED));
    plan.push_back(sample_row(16'h0000, 1'b1, DEEP_BLUE));
    // Zero gain, upper data bits ignored; offset alone sets the color
    plan.push_back(write_row(stcm_pkg::CFG_GAIN, 24'hFF0000));
    plan.push_back(write_row(stcm_pkg::CFG_OFFSET, 24'h7FFFFF));
    plan.push_back(sample_row(16'h5555, 1'b1, DARK_RED));
    plan.push_back(write_row(stcm_pkg::CFG_OFFSET, 24'h010000));
    plan.push_back(sample_row(16'hAAAA, 1'b1, DARK_RED));
    plan.push_back(write_row(stcm_pkg::CFG_OFFSET, 24'h008000));
    plan.push_back(sample_row(16'h1234, 1'b0, '0));

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed rows; writes only with the pipe empty
    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE) begin
        settle_pipeline();
        write_reg(plan[k].reg_idx, plan[k].word);
      end else begin
        send_sample(plan[k].word[stcm_pkg::SAMPLE_W-1:0], plan[k].typed, plan[k].color);
      end
    end

    // Random phases, each with its own settings and idling style
    for (int ph = 0; ph < PHASES; ph++) begin
      settle_pipeline();
      pick_phase_config();
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_LEN; k++) begin
        if (k == 40 && (ph == 0 || $urandom_range(0, 2) == 0)) settle_pipeline();
        send_sample(pick_sample(), 1'b0, '0);
      end
    end

    settle_pipeline();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
